// ----- rtl/trls_pkg.sv -----
// Shared types and constants of the thrust map gain estimator.
package trls_pkg;

  // Command codes of the input channel
  localparam logic [1:0] CMD_RECORD  = 2'd0;
  localparam logic [1:0] CMD_MEASURE = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [3:0] REG_ENABLE   = 4'd0;
  localparam logic [3:0] REG_GRAVITY  = 4'd1;
  localparam logic [3:0] REG_HOVER    = 4'd2;
  localparam logic [3:0] REG_FORGET   = 4'd3;
  localparam logic [3:0] REG_MIN_DLY  = 4'd4;
  localparam logic [3:0] REG_MAX_DLY  = 4'd5;
  localparam logic [3:0] REG_MIN_HOV  = 4'd6;
  localparam logic [3:0] REG_MAX_HOV  = 4'd7;

  // Register reset values
  localparam logic [23:0] GRAVITY_RST = 24'd642908;
  localparam logic [15:0] HOVER_RST   = 16'd19661;
  localparam logic [16:0] FORGET_RST  = 17'd64881;
  localparam logic [31:0] MIN_DLY_RST = 32'd35000;
  localparam logic [31:0] MAX_DLY_RST = 32'd45000;
  localparam logic [15:0] MIN_HOV_RST = 16'd6554;
  localparam logic [15:0] MAX_HOV_RST = 16'd58982;

  localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;
  localparam logic [47:0] COV_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] COV_INIT = 48'(64'd1000000 << 24);
  localparam logic [23:0] GAIN_RST = 24'((64'd642908 << 16) / 64'd19661);

  // Shared arithmetic unit
  localparam int unsigned ACC_W = 96;
  localparam int unsigned OPB_W = 49;
  localparam int unsigned NB_W  = 7;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [NB_W-1:0]   nbits;
  } alu_req_t;

endpackage

// ----- rtl/thrust_map_rls_estimator.sv -----
// Thrust-to-acceleration gain estimator: scalar RLS with forgetting factor.
// Record divides accel by gain for the thrust unless trivial, then pushes; restart may divide for the gain.
// Measure: a disabled measure goes straight to the result; else it drops stale samples, stops at a young
// sample and runs the RLS update per used sample (plus a gain divide when clamped).
// Throughput: one transaction at a time; the shared serial multiply/divide unit sets the rate.
// Reset: control, config and gain/covariance load reset values; FIFO empty, RAMs not cleared.
// Output register lets a new transaction start while a result still waits.
module thrust_map_rls_estimator #(
  parameter int unsigned QUEUE_DEPTH = 64,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        timestamp_us_i,
  input  logic signed [23:0] accel_value_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        thrust_cmd_o,
  output logic               thrust_saturated_o,
  output logic [23:0]        accel_per_thrust_o,
  output logic [CW-1:0]      samples_used_o,
  output logic [CW-1:0]      samples_dropped_o,
  output logic [CW-1:0]      queue_count_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  // Sequencer states, one-hot
  typedef enum logic [15:0] {
    S_IDLE = 16'b0000_0000_0000_0001,
    S_THR  = 16'b0000_0000_0000_0010,
    S_PUSH = 16'b0000_0000_0000_0100,
    S_RD   = 16'b0000_0000_0000_1000,
    S_CHK  = 16'b0000_0000_0001_0000,
    S_TT   = 16'b0000_0000_0010_0000,
    S_X    = 16'b0000_0000_0100_0000,
    S_GT   = 16'b0000_0000_1000_0000,
    S_PT   = 16'b0000_0001_0000_0000,
    S_N    = 16'b0000_0010_0000_0000,
    S_DQ   = 16'b0000_0100_0000_0000,
    S_DP   = 16'b0000_1000_0000_0000,
    S_HMAX = 16'b0001_0000_0000_0000,
    S_HMIN = 16'b0010_0000_0000_0000,
    S_GFF  = 16'b0100_0000_0000_0000,
    S_OUT  = 16'b1000_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic        en_q;
  logic [23:0] grav_q;
  logic [15:0] hov_q;
  logic [16:0] ff_q;
  logic [31:0] mind_q, maxd_q;
  logic [15:0] minh_q, maxh_q;

  // estimator state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [23:0]   gain_q, gain_d;
  logic [47:0]   cov_q, cov_d;

  // per-transaction working registers
  logic [1:0]    cmd_q, cmd_d;
  logic [31:0]   now_q, now_d;
  logic [23:0]   accel_q, accel_d;
  logic [15:0]   thr_q, thr_d;
  logic          sat_q, sat_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] drop_q, drop_d;
  logic [15:0]   t_q, t_d;
  logic [48:0]   d_q, d_d;
  logic [24:0]   abse_q, abse_d;
  logic          eneg_q, eneg_d;
  logic          above_q, above_d;
  logic [15:0]   frac_q, frac_d;
  logic [88:0]   prod_q, prod_d;
  logic          go_q, go_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [15:0]   o_thr_q;
  logic          o_sat_q;
  logic [23:0]   o_gain_q;
  logic [CW-1:0] o_used_q, o_drop_q, o_fill_q;
  logic          out_load;

  // shared arithmetic unit
  trls_pkg::alu_req_t         alu_req;
  logic [trls_pkg::ACC_W-1:0] alu_a;
  logic [trls_pkg::OPB_W-1:0] alu_b;
  logic [trls_pkg::ACC_W-1:0] alu_res;
  logic                       alu_done;
  logic                       use_alu;

  // sample memories
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_t_rd;
  logic [15:0]   ram_p_rd;

  // datapath helpers
  logic [AW-1:0] head_inc;
  logic [AW-1:0] push_head;
  logic [CW-1:0] push_fill;
  logic [AW:0]   push_sum;
  logic          fifo_full;
  logic [31:0]   age;
  logic [16:0]   lam;
  logic [25:0]   err;
  logic [72:0]   q_sh;
  logic [25:0]   delta;
  logic [26:0]   gsum;
  logic [23:0]   gain_upd;
  logic [39:0]   grav_sh;
  logic          below;
  logic [15:0]   clamp_frac;
  logic          clamp_any;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  // FIFO pointer arithmetic; depth need not be a power of two
  assign head_inc  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign fifo_full = (fill_q == CW'(QUEUE_DEPTH));
  assign push_head = fifo_full ? head_inc : head_q;
  assign push_fill = fifo_full ? CW'(QUEUE_DEPTH - 1) : fill_q;
  always_comb begin
    push_sum = {1'b0, push_head} + (AW + 1)'(push_fill);
    if (push_sum >= (AW + 1)'(QUEUE_DEPTH)) begin
      push_sum = push_sum - (AW + 1)'(QUEUE_DEPTH);
    end
  end
  assign ram_waddr = push_sum[AW-1:0];

  // Wrapping age: a stamp ahead of now looks very old
  assign age = now_q - ram_t_rd;

  // Forgetting factor forced into 1..65536
  assign lam = (ff_q == 17'd0) ? 17'd1 :
               (ff_q[16] && (ff_q[15:0] != 16'd0)) ? 17'h10000 : ff_q;

  // Prediction error E = accel - gain*T (Q8.16)
  assign err = {{2{accel_q[23]}}, accel_q} - {2'b00, alu_res[39:16]};

  // Gain correction, saturated to 2^25, applied with the sign of E
  assign q_sh  = alu_res[88:16];
  assign delta = ((q_sh[72:26] != '0) || (q_sh[25:0] > 26'h2000000)) ?
                 26'h2000000 : q_sh[25:0];
  assign gsum  = eneg_q ? ({3'b000, gain_q} - {1'b0, delta})
                        : ({3'b000, gain_q} + {1'b0, delta});
  assign gain_upd = gsum[26] ? 24'd0 :
                    (gsum[25:24] != 2'b00) ? trls_pkg::GAIN_MAX : gsum[23:0];

  // Hover clamp: lower bound wins over upper bound
  assign grav_sh    = {grav_q, 16'd0};
  assign below      = (grav_sh < alu_res[39:0]);
  assign clamp_any  = below || above_q;
  assign clamp_frac = below ? minh_q : maxh_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    gain_d      = gain_q;
    cov_d       = cov_q;
    cmd_d       = cmd_q;
    now_d       = now_q;
    accel_d     = accel_q;
    thr_d       = thr_q;
    sat_d       = sat_q;
    used_d      = used_q;
    drop_d      = drop_q;
    t_d         = t_q;
    d_d         = d_q;
    abse_d      = abse_q;
    eneg_d      = eneg_q;
    above_d     = above_q;
    frac_d      = frac_q;
    prod_d      = prod_q;
    go_d        = go_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    use_alu     = 1'b0;
    alu_req.op    = trls_pkg::OP_MUL;
    alu_req.nbits = trls_pkg::NB_W'(1);
    alu_a       = '0;
    alu_b       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          now_d   = timestamp_us_i;
          accel_d = accel_value_i;
          thr_d   = 16'd0;
          sat_d   = 1'b0;
          used_d  = '0;
          drop_d  = '0;
          case (cmd_i)
            trls_pkg::CMD_RECORD: begin
              if (accel_value_i[23]) begin
                sat_d   = 1'b1;
                state_d = S_PUSH;
              end else if (accel_value_i == 24'sd0) begin
                state_d = S_PUSH;
              end else if (gain_q == 24'd0) begin
                thr_d   = 16'hFFFF;
                sat_d   = 1'b1;
                state_d = S_PUSH;
              end else begin
                state_d = S_THR;
              end
            end
            trls_pkg::CMD_MEASURE: begin
              state_d = en_q ? S_RD : S_OUT;
            end
            trls_pkg::CMD_RESTART: begin
              cov_d = trls_pkg::COV_INIT;
              if (hov_q == 16'd0) begin
                gain_d  = (grav_q != 24'd0) ? trls_pkg::GAIN_MAX : 24'd0;
                state_d = S_OUT;
              end else begin
                frac_d  = hov_q;
                state_d = S_GFF;
              end
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_THR: begin
        use_alu       = 1'b1;
        alu_req.op    = trls_pkg::OP_DIV;
        alu_req.nbits = trls_pkg::NB_W'(39);
        alu_a         = {accel_q[22:0], 16'd0, 57'd0};
        alu_b         = trls_pkg::OPB_W'(gain_q);
        if (alu_done) begin
          if (alu_res[38:16] != '0) begin
            thr_d = 16'hFFFF;
            sat_d = 1'b1;
          end else begin
            thr_d = alu_res[15:0];
          end
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        // Overflow drops the oldest entry before the push
        if (fifo_full) begin
          drop_d = CW'(1);
        end
        ram_we  = 1'b1;
        head_d  = push_head;
        fill_d  = push_fill + 1'b1;
        state_d = S_OUT;
      end
      S_RD: begin
        if (fill_q == '0) begin
          state_d = S_OUT;
        end else begin
          ram_re  = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (age > maxd_q) begin
          drop_d  = drop_q + 1'b1;
          head_d  = head_inc;
          fill_d  = fill_q - 1'b1;
          state_d = S_RD;
        end else if (age < mind_q) begin
          state_d = S_OUT;
        end else begin
          used_d  = used_q + 1'b1;
          head_d  = head_inc;
          fill_d  = fill_q - 1'b1;
          t_d     = ram_p_rd;
          state_d = S_TT;
        end
      end
      S_TT: begin
        use_alu       = 1'b1;
        alu_req.nbits = trls_pkg::NB_W'(16);
        alu_a         = trls_pkg::ACC_W'(t_q);
        alu_b         = trls_pkg::OPB_W'(t_q);
        if (alu_done) begin
          prod_d  = 89'(alu_res[31:0]);
          state_d = S_X;
        end
      end
      S_X: begin
        // D = lambda<<8 + (T*T*P)>>32
        use_alu       = 1'b1;
        alu_req.nbits = trls_pkg::NB_W'(32);
        alu_a         = trls_pkg::ACC_W'(cov_q);
        alu_b         = trls_pkg::OPB_W'(prod_q[31:0]);
        if (alu_done) begin
          d_d     = 49'({lam, 8'd0}) + 49'(alu_res[79:32]);
          state_d = S_GT;
        end
      end
      S_GT: begin
        use_alu       = 1'b1;
        alu_req.nbits = trls_pkg::NB_W'(16);
        alu_a         = trls_pkg::ACC_W'(gain_q);
        alu_b         = trls_pkg::OPB_W'(t_q);
        if (alu_done) begin
          eneg_d  = err[25];
          abse_d  = err[25] ? 25'(-err) : err[24:0];
          state_d = S_PT;
        end
      end
      S_PT: begin
        use_alu       = 1'b1;
        alu_req.nbits = trls_pkg::NB_W'(16);
        alu_a         = trls_pkg::ACC_W'(cov_q);
        alu_b         = trls_pkg::OPB_W'(t_q);
        if (alu_done) begin
          prod_d  = 89'(alu_res[63:0]);
          state_d = S_N;
        end
      end
      S_N: begin
        use_alu       = 1'b1;
        alu_req.nbits = trls_pkg::NB_W'(25);
        alu_a         = trls_pkg::ACC_W'(prod_q[63:0]);
        alu_b         = trls_pkg::OPB_W'(abse_q);
        if (alu_done) begin
          prod_d  = alu_res[88:0];
          state_d = S_DQ;
        end
      end
      S_DQ: begin
        use_alu       = 1'b1;
        alu_req.op    = trls_pkg::OP_DIV;
        alu_req.nbits = trls_pkg::NB_W'(89);
        alu_a         = {prod_q, 7'd0};
        alu_b         = d_q;
        if (alu_done) begin
          gain_d  = gain_upd;
          state_d = S_DP;
        end
      end
      S_DP: begin
        // P = P*2^24 / D
        use_alu       = 1'b1;
        alu_req.op    = trls_pkg::OP_DIV;
        alu_req.nbits = trls_pkg::NB_W'(72);
        alu_a         = {cov_q, 48'd0};
        alu_b         = d_q;
        if (alu_done) begin
          cov_d   = (alu_res[71:48] != '0) ? trls_pkg::COV_MAX : alu_res[47:0];
          state_d = S_HMAX;
        end
      end
      S_HMAX: begin
        use_alu       = 1'b1;
        alu_req.nbits = trls_pkg::NB_W'(16);
        alu_a         = trls_pkg::ACC_W'(gain_q);
        alu_b         = trls_pkg::OPB_W'(maxh_q);
        if (alu_done) begin
          above_d = (grav_sh > alu_res[39:0]);
          state_d = S_HMIN;
        end
      end
      S_HMIN: begin
        use_alu       = 1'b1;
        alu_req.nbits = trls_pkg::NB_W'(16);
        alu_a         = trls_pkg::ACC_W'(gain_q);
        alu_b         = trls_pkg::OPB_W'(minh_q);
        if (alu_done) begin
          if (!clamp_any) begin
            state_d = S_RD;
          end else if (clamp_frac == 16'd0) begin
            gain_d  = (grav_q != 24'd0) ? trls_pkg::GAIN_MAX : 24'd0;
            state_d = S_RD;
          end else begin
            frac_d  = clamp_frac;
            state_d = S_GFF;
          end
        end
      end
      S_GFF: begin
        // gain = gravity*2^16 / fraction, saturated
        use_alu       = 1'b1;
        alu_req.op    = trls_pkg::OP_DIV;
        alu_req.nbits = trls_pkg::NB_W'(40);
        alu_a         = {grav_q, 16'd0, 56'd0};
        alu_b         = trls_pkg::OPB_W'(frac_q);
        if (alu_done) begin
          gain_d  = (alu_res[39:24] != '0) ? trls_pkg::GAIN_MAX : alu_res[23:0];
          state_d = (cmd_q == trls_pkg::CMD_RESTART) ? S_OUT : S_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    alu_req.start = use_alu && !go_q;
    if (alu_req.start) begin
      go_d = 1'b1;
    end else if (alu_done) begin
      go_d = 1'b0;
    end
  end

  trls_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .done_o (alu_done)
  );

  trls_ram #(
    .WIDTH (32),
    .DEPTH (QUEUE_DEPTH)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (now_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_t_rd)
  );

  trls_ram #(
    .WIDTH (16),
    .DEPTH (QUEUE_DEPTH)
  ) u_thrust_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (thr_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_p_rd)
  );

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b1;
      grav_q <= trls_pkg::GRAVITY_RST;
      hov_q  <= trls_pkg::HOVER_RST;
      ff_q   <= trls_pkg::FORGET_RST;
      mind_q <= trls_pkg::MIN_DLY_RST;
      maxd_q <= trls_pkg::MAX_DLY_RST;
      minh_q <= trls_pkg::MIN_HOV_RST;
      maxh_q <= trls_pkg::MAX_HOV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        trls_pkg::REG_ENABLE:  en_q   <= cfg_data_i[0];
        trls_pkg::REG_GRAVITY: grav_q <= cfg_data_i[23:0];
        trls_pkg::REG_HOVER:   hov_q  <= cfg_data_i[15:0];
        trls_pkg::REG_FORGET:  ff_q   <= cfg_data_i[16:0];
        trls_pkg::REG_MIN_DLY: mind_q <= cfg_data_i;
        trls_pkg::REG_MAX_DLY: maxd_q <= cfg_data_i;
        trls_pkg::REG_MIN_HOV: minh_q <= cfg_data_i[15:0];
        trls_pkg::REG_MAX_HOV: maxh_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Control and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      gain_q      <= trls_pkg::GAIN_RST;
      cov_q       <= trls_pkg::COV_INIT;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      gain_q      <= gain_d;
      cov_q       <= cov_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    now_q   <= now_d;
    accel_q <= accel_d;
    thr_q   <= thr_d;
    sat_q   <= sat_d;
    used_q  <= used_d;
    drop_q  <= drop_d;
    t_q     <= t_d;
    d_q     <= d_d;
    abse_q  <= abse_d;
    eneg_q  <= eneg_d;
    above_q <= above_d;
    frac_q  <= frac_d;
    prod_q  <= prod_d;
    if (out_load) begin
      o_thr_q  <= thr_q;
      o_sat_q  <= sat_q;
      o_gain_q <= gain_q;
      o_used_q <= used_q;
      o_drop_q <= drop_q;
      o_fill_q <= fill_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign thrust_cmd_o       = o_thr_q;
  assign thrust_saturated_o = o_sat_q;
  assign accel_per_thrust_o = o_gain_q;
  assign samples_used_o     = o_used_q;
  assign samples_dropped_o  = o_drop_q;
  assign queue_count_o      = o_fill_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(QUEUE_DEPTH))
    else $error("FIFO fill above depth");

  a_alu_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> go_q)
    else $error("arithmetic result with no step waiting");

  a_meas_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (cmd_i == trls_pkg::CMD_MEASURE) && !en_q)
      |=> (state_q == S_OUT))
    else $error("disabled measure did not go straight to result");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the result state");

endmodule

// ----- rtl/trls_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module trls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/trls_alu.sv -----
// Shared bit-serial multiplier and restoring divider.
module trls_alu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  trls_pkg::alu_req_t          req_i,
  input  logic [trls_pkg::ACC_W-1:0]  a_i,
  input  logic [trls_pkg::OPB_W-1:0]  b_i,
  output logic [trls_pkg::ACC_W-1:0]  res_o,
  output logic                        done_o
);

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [trls_pkg::NB_W-1:0]   cnt_q, cnt_d;
  trls_pkg::alu_op_e           op_q, op_d;
  logic [trls_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [trls_pkg::ACC_W-1:0]  opa_q, opa_d;
  logic [trls_pkg::OPB_W-1:0]  opb_q, opb_d;
  logic [trls_pkg::OPB_W:0]    rem2;
  logic [trls_pkg::OPB_W:0]    rem_sub;
  logic                        ge;

  // Divide step: shift in next dividend bit, subtract divisor if it fits
  assign rem2    = {opa_q[trls_pkg::OPB_W-1:0], acc_q[trls_pkg::ACC_W-1]};
  assign rem_sub = rem2 - {1'b0, opb_q};
  assign ge      = (rem2 >= {1'b0, opb_q});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    if (req_i.start) begin
      run_d = 1'b1;
      op_d  = req_i.op;
      cnt_d = req_i.nbits;
      opb_d = b_i;
      if (req_i.op == trls_pkg::OP_DIV) begin
        acc_d = a_i;
        opa_d = '0;
      end else begin
        acc_d = '0;
        opa_d = a_i;
      end
    end else if (run_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == trls_pkg::NB_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
      case (op_q)
        trls_pkg::OP_MUL: begin
          if (opb_q[0]) begin
            acc_d = acc_q + opa_q;
          end
          opa_d = {opa_q[trls_pkg::ACC_W-2:0], 1'b0};
          opb_d = {1'b0, opb_q[trls_pkg::OPB_W-1:1]};
        end
        trls_pkg::OP_DIV: begin
          opa_d = trls_pkg::ACC_W'(ge ? rem_sub[trls_pkg::OPB_W-1:0]
                                      : rem2[trls_pkg::OPB_W-1:0]);
          acc_d = {acc_q[trls_pkg::ACC_W-2:0], ge};
        end
        default: begin
          run_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
  end

  assign res_o  = acc_q;
  assign done_o = done_q;

endmodule
